@@ rtl/tadc_pkg.sv @@
package tadc_pkg;

  // Default samples averaged into one reading
  localparam int SamplesDefault = 10;

  // Field and state widths
  localparam int SampleWidth = 10;
  localparam int SumWidth    = 14;
  localparam int CountWidth  = 4;
  localparam int TempWidth   = 6;
  localparam int ResWidth    = 23;
  localparam int MeanWidth   = 10;
  localparam int MvWidth     = 12;
  localparam int ProdWidth   = 22;

  // Divider sizing
  localparam int DivWidth      = 25;
  localparam int DivisorWidth  = 14;
  localparam int DivCountWidth = 5;

  // Conversion constants
  localparam int VrefMv   = 3300;
  localparam int AdcShift = 10;
  localparam int RFixed   = 10000;
  localparam int SegScale = 10;

  // Piecewise-linear segments: open interval (lo, hi), slope in tenths, base
  localparam int SegCount     = 6;
  localparam int SegWidth     = 16;
  localparam int SegIdxWidth  = 3;
  localparam int SegQuotWidth = 4;
  localparam logic [SegWidth-1:0] SegLo [SegCount] =
    '{16'd20310, 16'd12570, 16'd8034, 16'd5298, 16'd3586, 16'd2484};
  localparam logic [SegWidth-1:0] SegHi [SegCount] =
    '{16'd33970, 16'd20310, 16'd12570, 16'd8034, 16'd5298, 16'd3586};
  localparam logic [DivisorWidth-1:0] SegK [SegCount] =
    '{14'd13660, 14'd7740, 14'd4537, 14'd2737, 14'd1717, 14'd1102};
  localparam logic [TempWidth-1:0] SegBase [SegCount] =
    '{6'd0, 6'd10, 6'd20, 6'd30, 6'd40, 6'd50};

  // Reading queue sizing
  localparam int QueueDepth      = 2;
  localparam int QueuePtrWidth   = 1;
  localparam int QueueCountWidth = 2;

  typedef struct packed {
    logic                valid;
    logic [SumWidth-1:0] sum;
  } reading_t;

  typedef struct packed {
    logic                    start;
    logic [DivWidth-1:0]     dividend;
    logic [DivisorWidth-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DivWidth-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/tadc_front.sv @@
module tadc_front #(
  parameter int SAMPLES_PER_READING = tadc_pkg::SamplesDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic [tadc_pkg::SampleWidth-1:0] sample,
  output tadc_pkg::reading_t               push
);
  import tadc_pkg::*;

  logic [SumWidth-1:0]   sample_sum;
  logic [CountWidth-1:0] sample_count;
  logic [SumWidth-1:0]   sum_next;
  logic                  last;

  // Add the new item to the running sum
  assign sum_next = sample_sum + SumWidth'(sample);
  assign last     = (sample_count == CountWidth'(SAMPLES_PER_READING - 1));

  // Hand a completed reading to the queue
  assign push.valid = accept && last;
  assign push.sum   = sum_next;

  // Hold the running sum and count
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum   <= '0;
      sample_count <= '0;
    end else if (accept) begin
      if (last) begin
        sample_sum   <= '0;
        sample_count <= '0;
      end else begin
        sample_sum   <= sum_next;
        sample_count <= sample_count + CountWidth'(1);
      end
    end
  end

endmodule

@@ rtl/tadc_queue.sv @@
module tadc_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  tadc_pkg::reading_t         push,
  input  logic                       pop,
  output tadc_pkg::reading_t         head,
  output logic                       full
);
  import tadc_pkg::*;

  logic [SumWidth-1:0]        entries [QueueDepth];
  logic [QueuePtrWidth-1:0]   wr_ptr;
  logic [QueuePtrWidth-1:0]   rd_ptr;
  logic [QueueCountWidth-1:0] fill;
  logic                       do_pop;

  assign full       = (fill == QueueCountWidth'(QueueDepth));
  assign head.valid = (fill != '0);
  assign head.sum   = entries[rd_ptr];
  assign do_pop     = pop && head.valid;

  // Write the incoming reading
  always_ff @(posedge clk) begin
    if (push.valid) begin
      entries[wr_ptr] <= push.sum;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + QueuePtrWidth'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QueuePtrWidth'(1);
      end
      if (push.valid && !do_pop) begin
        fill <= fill + QueueCountWidth'(1);
      end else if (do_pop && !push.valid) begin
        fill <= fill - QueueCountWidth'(1);
      end
    end
  end

endmodule

@@ rtl/tadc_divider.sv @@
module tadc_divider (
  input  logic               clk,
  input  logic               rst,
  input  tadc_pkg::div_req_t req,
  output tadc_pkg::div_rsp_t rsp
);
  import tadc_pkg::*;

  logic                     running;
  logic                     done;
  logic [DivCountWidth-1:0] step;
  logic [DivisorWidth:0]    rem;
  logic [DivWidth-1:0]      quo;
  logic [DivisorWidth-1:0]  dvsr;
  logic [DivisorWidth:0]    shifted;
  logic                     ge;

  // Bring down one dividend bit and trial-subtract
  assign shifted = {rem[DivisorWidth-1:0], quo[DivWidth-1]};
  assign ge      = (shifted >= {1'b0, dvsr});

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  // One quotient bit per cycle, restoring form
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        step    <= DivCountWidth'(DivWidth - 1);
        rem     <= '0;
        quo     <= req.dividend;
        dvsr    <= req.divisor;
      end else if (running) begin
        rem  <= ge ? (shifted - {1'b0, dvsr}) : shifted;
        quo  <= {quo[DivWidth-2:0], ge};
        step <= step - DivCountWidth'(1);
        if (step == '0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/tadc_back.sv @@
module tadc_back #(
  parameter int SAMPLES_PER_READING = tadc_pkg::SamplesDefault
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tadc_pkg::reading_t             head,
  output logic                           pop,
  output logic                           done,
  output logic [tadc_pkg::TempWidth-1:0] temperature,
  output logic                           out_of_range,
  output logic [tadc_pkg::ResWidth-1:0]  resistance
);
  import tadc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MV, S_SCALE, S_RES, S_SEG, S_TEMP
  } state_t;

  // Reciprocal for the mean, exact for every sum of SumWidth bits
  localparam int MeanShift     = SumWidth + $clog2(SAMPLES_PER_READING);
  localparam int MeanRecip     =
    ((1 << MeanShift) + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING;
  localparam int RecipWidth    = SumWidth + 2;
  localparam int MeanProdWidth = SumWidth + RecipWidth;

  state_t                   state;
  div_req_t                 req;
  div_rsp_t                 rsp;
  logic [MeanProdWidth-1:0] mean_prod;
  logic [MeanWidth-1:0]     mean;
  logic [MvWidth-1:0]       mv;
  logic [ResWidth-1:0]      res_r;
  logic [TempWidth-1:0]     base_r;
  logic [TempWidth-1:0]     held_temperature;
  logic                     seg_hit;
  logic [ResWidth-1:0]      seg_dividend;
  logic [SegIdxWidth-1:0]   seg_idx;
  logic [TempWidth-1:0]     seg_base;
  logic [ResWidth-1:0]      seg_num_r;
  logic [SegIdxWidth-1:0]   seg_idx_r;
  logic [SegQuotWidth-1:0]  seg_quot;
  logic [TempWidth-1:0]     temp_new;

  tadc_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  assign pop       = (state == S_IDLE) && head.valid;
  assign mean_prod = MeanProdWidth'(head.sum) * MeanProdWidth'(MeanRecip);
  assign temp_new  = TempWidth'(seg_quot) + base_r;

  // Match the resistance against every open segment
  always_comb begin
    seg_hit      = 1'b0;
    seg_dividend = '0;
    seg_idx      = '0;
    seg_base     = '0;
    for (int i = SegCount - 1; i >= 0; i--) begin
      if (res_r > ResWidth'(SegLo[i]) && res_r < ResWidth'(SegHi[i])) begin
        seg_hit      = 1'b1;
        seg_dividend = (ResWidth'(SegHi[i]) - res_r) * ResWidth'(SegScale);
        seg_idx      = SegIdxWidth'(i);
        seg_base     = SegBase[i];
      end
    end
  end

  // Divide by the slope: the numerator stays below ten slopes, so compare
  // against each multiple and keep the largest one reached
  always_comb begin
    seg_quot = '0;
    for (int i = 0; i < SegCount; i++) begin
      for (int j = 1; j < SegScale; j++) begin
        if (seg_idx_r == SegIdxWidth'(i) &&
            seg_num_r >= ResWidth'(SegK[i]) * ResWidth'(j)) begin
          seg_quot = SegQuotWidth'(j);
        end
      end
    end
  end

  // Sequence mean, millivolts, resistance, segment match and the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      req              <= '0;
      done             <= 1'b0;
      held_temperature <= '0;
    end else begin
      req.start <= 1'b0;
      done      <= 1'b0;
      case (state)
        S_IDLE: begin
          if (head.valid) begin
            mean  <= MeanWidth'(mean_prod >> MeanShift);
            state <= S_MV;
          end
        end
        S_MV: begin
          mv    <= MvWidth'((ProdWidth'(mean) * ProdWidth'(VrefMv)) >> AdcShift);
          state <= S_SCALE;
        end
        S_SCALE: begin
          req.start    <= 1'b1;
          req.dividend <= DivWidth'(mv) * DivWidth'(RFixed);
          req.divisor  <= DivisorWidth'(MvWidth'(VrefMv) - mv);
          state        <= S_RES;
        end
        S_RES: begin
          if (rsp.done) begin
            res_r <= rsp.quotient[ResWidth-1:0];
            state <= S_SEG;
          end
        end
        S_SEG: begin
          if (seg_hit) begin
            seg_num_r <= seg_dividend;
            seg_idx_r <= seg_idx;
            base_r    <= seg_base;
            state     <= S_TEMP;
          end else begin
            // Repeat the held value and flag it
            done         <= 1'b1;
            temperature  <= held_temperature;
            out_of_range <= 1'b1;
            resistance   <= res_r;
            state        <= S_IDLE;
          end
        end
        S_TEMP: begin
          done             <= 1'b1;
          temperature      <= temp_new;
          out_of_range     <= 1'b0;
          resistance       <= res_r;
          held_temperature <= temp_new;
          state            <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/thermistor_adc_to_temperature.sv @@
// Thermistor ADC to temperature. Each 10-bit sample is taken at the edge where
// start is high and busy is low, one sample per cycle at most; every
// SAMPLES_PER_READING samples form one reading and give one result. The
// result (temperature, out_of_range, resistance) is shown for exactly one
// cycle with done high and cannot be held off, so it must be captured then.
// A reading passes through a reciprocal multiply for the mean, a multiply for
// millivolts, the start and load of the bit-serial divider, its 25 steps for
// the resistance, then the segment match and, when a segment matches, a
// one-digit slope quotient by constant compares. The back end takes a new
// reading only after it has given the result of the last one. Two completed
// readings can wait in a queue; busy is high while it is full. A resistance
// on a segment boundary or outside all segments repeats the last in-range
// temperature with out_of_range set.
module thermistor_adc_to_temperature #(
  parameter int SAMPLES_PER_READING = tadc_pkg::SamplesDefault
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [tadc_pkg::SampleWidth-1:0] sample,
  output logic                             busy,
  output logic                             done,
  output logic [tadc_pkg::TempWidth-1:0]   temperature,
  output logic                             out_of_range,
  output logic [tadc_pkg::ResWidth-1:0]    resistance
);
  import tadc_pkg::*;

  reading_t push;
  reading_t head;
  logic     pop;
  logic     q_full;

  assign busy = q_full;

  tadc_front #(
    .SAMPLES_PER_READING (SAMPLES_PER_READING)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (start && !busy),
    .sample (sample),
    .push   (push)
  );

  tadc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (q_full)
  );

  tadc_back #(
    .SAMPLES_PER_READING (SAMPLES_PER_READING)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .done         (done),
    .temperature  (temperature),
    .out_of_range (out_of_range),
    .resistance   (resistance)
  );

  // Check: no reading is pushed into a full queue
  assert property (@(posedge clk) disable iff (rst) push.valid |-> !q_full)
    else $error("reading pushed into full queue");

  // Check: resistance stays within the divider's reachable range
  assert property (@(posedge clk) disable iff (rst) done |-> resistance <= 23'd8240000)
    else $error("resistance out of range");

  // Check: an in-range result lies within the segment span
  assert property (@(posedge clk) disable iff (rst)
    (done && !out_of_range) |-> (temperature <= 6'd60 && resistance > 23'd2484))
    else $error("in-range result outside segment span");

endmodule

@@ bench/thermistor_adc_to_temperature_checker.sv @@
`timescale 1ns / 1ps

module thermistor_adc_to_temperature_checker #(
  parameter int SamplesPerReading = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [9:0]  sample,
  input  logic        busy,
  input  logic        done,
  input  logic [5:0]  temperature,
  input  logic        out_of_range,
  input  logic [22:0] resistance,
  output int          mismatch_count,
  output int          readings_pending
);

  typedef struct packed {
    logic [5:0]  temperature;
    logic        out_of_range;
    logic [22:0] resistance;
  } temp_result_t;

  // Open segments (low, high), slope in tenths of ohms per degree, base degrees
  localparam int unsigned SegLowOhms  [6] = '{20310, 12570, 8034, 5298, 3586, 2484};
  localparam int unsigned SegHighOhms [6] = '{33970, 20310, 12570, 8034, 5298, 3586};
  localparam int unsigned SegSlope    [6] = '{13660, 7740, 4537, 2737, 1717, 1102};
  localparam int unsigned SegBaseDeg  [6] = '{0, 10, 20, 30, 40, 50};

  temp_result_t reading_q [$];
  logic [13:0]  sum_acc;
  int unsigned  sample_cnt;
  logic [5:0]   held_deg;

  assign readings_pending = reading_q.size();

  // Mean, millivolts, divider resistance, then segment lookup
  function automatic temp_result_t convert_reading(input logic [13:0] sum,
                                                   input logic [5:0] held);
    int unsigned mean;
    int unsigned mv;
    int unsigned ohms;
    int unsigned deg;
    temp_result_t res;
    mean = sum / SamplesPerReading;
    mv   = (mean * 3300) / 1024;
    ohms = (mv * 10000) / (3300 - mv);
    res.temperature  = held;
    res.out_of_range = 1'b1;
    res.resistance   = ohms[22:0];
    for (int i = 0; i < 6; i++) begin
      if (res.out_of_range && ohms > SegLowOhms[i] && ohms < SegHighOhms[i]) begin
        deg = ((SegHighOhms[i] - ohms) * 10) / SegSlope[i] + SegBaseDeg[i];
        res.temperature  = deg[5:0];
        res.out_of_range = 1'b0;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    logic [13:0]  sum_next;
    temp_result_t exp_res;
    if (rst) begin
      reading_q.delete();
      sum_acc        = '0;
      sample_cnt     = 0;
      held_deg       = '0;
      mismatch_count = 0;
    end else begin
      // Compare each result with the oldest expected reading
      if (done) begin
        if (reading_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: temp %0d oor %0b res %0d",
                     temperature, out_of_range, resistance);
        end else begin
          exp_res = reading_q.pop_front();
          if (temperature !== exp_res.temperature ||
              out_of_range !== exp_res.out_of_range ||
              resistance !== exp_res.resistance) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected temp %0d oor %0b res %0d, got temp %0d oor %0b res %0d",
                       exp_res.temperature, exp_res.out_of_range, exp_res.resistance,
                       temperature, out_of_range, resistance);
          end
        end
      end
      // Accumulate each accepted item; predict on the last of a reading
      if (start && !busy) begin
        sum_next = sum_acc + {4'd0, sample};
        if (sample_cnt + 1 < SamplesPerReading) begin
          sum_acc    = sum_next;
          sample_cnt = sample_cnt + 1;
        end else begin
          exp_res = convert_reading(sum_next, held_deg);
          if (!exp_res.out_of_range)
            held_deg = exp_res.temperature;
          reading_q.push_back(exp_res);
          sum_acc    = '0;
          sample_cnt = 0;
        end
      end
    end
  end

endmodule

@@ bench/thermistor_adc_to_temperature_tb.sv @@
`timescale 1ns / 1ps

module thermistor_adc_to_temperature_tb;

  localparam int SamplesPerReading = 10;
  localparam int RandomReadings    = 160;
  localparam int CycleLimit        = 1000000;
  localparam int DrainCycles       = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [9:0]  sample = '0;
  logic        busy;
  logic        done;
  logic [5:0]  temperature;
  logic        out_of_range;
  logic [22:0] resistance;
  int          mismatch_count;
  int          readings_pending;

  always #1 clk = ~clk;

  thermistor_adc_to_temperature #(
    .SAMPLES_PER_READING(SamplesPerReading)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .sample(sample),
    .busy(busy),
    .done(done),
    .temperature(temperature),
    .out_of_range(out_of_range),
    .resistance(resistance)
  );

  thermistor_adc_to_temperature_checker #(
    .SamplesPerReading(SamplesPerReading)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .start(start),
    .sample(sample),
    .busy(busy),
    .done(done),
    .temperature(temperature),
    .out_of_range(out_of_range),
    .resistance(resistance),
    .mismatch_count(mismatch_count),
    .readings_pending(readings_pending)
  );

  // Offer one item, hold it until taken, then, unless no_gap is set, sometimes idle for a random gap
  task automatic send_sample(input int value, input bit no_gap);
    int pick;
    int gap;
    start  <= 1'b1;
    sample <= value[9:0];
    do @(posedge clk); while (busy);
    pick = $urandom_range(0, 99);
    if (no_gap || pick < 65)
      gap = 0;
    else if (pick < 93)
      gap = $urandom_range(1, 3);
    else
      gap = $urandom_range(20, 100);
    if (gap > 0) begin
      start  <= 1'b0;
      sample <= 10'($urandom_range(0, 1023));
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and wait for every expected reading to arrive
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (readings_pending != 0);
  endtask

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int mode;
    int target;
    int value;
    bit burst;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Full-scale reading, all-zero reading, then bit-pattern items
    for (int k = 0; k < SamplesPerReading; k++) send_sample(1023, 1'b0);
    for (int k = 0; k < SamplesPerReading; k++) send_sample(0, 1'b0);
    send_sample(10'h2aa, 1'b0);
    send_sample(10'h155, 1'b0);
    send_sample(1, 1'b0);
    send_sample(512, 1'b0);
    send_sample(1022, 1'b0);
    wait_drained();

    // Readings mostly near a steady level, some noisy, spanning all segments
    for (int rd = 0; rd < RandomReadings; rd++) begin
      if (rd == RandomReadings / 2)
        wait_drained();
      burst = ($urandom_range(0, 3) == 0);
      mode  = int'($urandom_range(0, 9));
      if (mode < 6)
        target = int'($urandom_range(180, 820));
      else
        target = int'($urandom_range(0, 1023));
      for (int k = 0; k < SamplesPerReading; k++) begin
        if (mode >= 8) begin
          value = int'($urandom_range(0, 1023));
        end else begin
          value = target + int'($urandom_range(0, 6)) - 3;
          if (value < 0) value = 0;
          if (value > 1023) value = 1023;
        end
        send_sample(value, burst);
      end
    end

    start <= 1'b0;
    while (readings_pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0 && readings_pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/tadc_pkg.sv
rtl/tadc_front.sv
rtl/tadc_queue.sv
rtl/tadc_divider.sv
rtl/tadc_back.sv
rtl/thermistor_adc_to_temperature.sv
bench/thermistor_adc_to_temperature_checker.sv
bench/thermistor_adc_to_temperature_tb.sv
